// ===== hw/rtl/atrp_pkg.sv =====
// Shared types, constants and angle table for the accelerometer tilt block.
package atrp_pkg;

  localparam int FRAC_BITS   = 13;
  localparam int CORDIC_ITER = 16;
  localparam int SQRT_STAGES = 24;   // result bits of floor(sqrt(s << 16))
  localparam int SQRT_IN_W   = 48;
  localparam int ROOT_W      = 24;
  localparam int REM_W       = 25;
  localparam int XY_W        = 27;
  localparam int Z_W         = 17;
  localparam int ANGLE_W     = 15;
  localparam int CODE_W      = 7;
  localparam int MAG_W       = 16;
  localparam int SUM_W       = 32;

  localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // round half up from 2^30 scale to FRAC_BITS
  function automatic logic [Z_W-1:0] q30_round(input logic [31:0] v);
    logic [32:0] t;
    t = {1'b0, v} + (33'd1 << (29 - FRAC_BITS));
    return Z_W'(t >> (30 - FRAC_BITS));
  endfunction

  localparam logic [Z_W-1:0] HALF_PI = q30_round(HALF_PI_Q30);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } accel_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic [CODE_W-1:0]         roll_code;
    logic [CODE_W-1:0]         pitch_code;
  } tilt_out_t;

  // per-item tag that rides along the pipeline; lane 0 is roll, lane 1 pitch
  typedef struct packed {
    logic                       vld;
    logic [1:0]                 neg;
    logic [1:0]                 zero;
    logic [1:0][MAG_W-1:0]      mag;
  } tag_t;

endpackage

// ===== hw/rtl/atrp_sumsq.sv =====
// Squares of the three axes and the two sums of squares, two stages.
module atrp_sumsq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  atrp_pkg::accel_in_t                 in_data,
  output atrp_pkg::tag_t                      tag_out,
  output logic [1:0][atrp_pkg::SUM_W-1:0]     sum_out
);
  import atrp_pkg::*;

  logic [SUM_W-1:0] sq_x, sq_y, sq_z;
  tag_t             tag1;
  tag_t             tag1_next;
  logic signed [31:0] px, py, pz;

  assign px = in_data.accel_x * in_data.accel_x;
  assign py = in_data.accel_y * in_data.accel_y;
  assign pz = in_data.accel_z * in_data.accel_z;

  always_comb begin
    tag1_next.vld     = in_vld;
    // roll numerator is accel_y, pitch numerator is -accel_x
    tag1_next.neg[0]  = in_data.accel_y[15];
    tag1_next.zero[0] = (in_data.accel_y == 16'sd0);
    tag1_next.mag[0]  = in_data.accel_y[15] ? MAG_W'(-in_data.accel_y)
                                            : MAG_W'(in_data.accel_y);
    tag1_next.neg[1]  = !in_data.accel_x[15] && (in_data.accel_x != 16'sd0);
    tag1_next.zero[1] = (in_data.accel_x == 16'sd0);
    tag1_next.mag[1]  = in_data.accel_x[15] ? MAG_W'(-in_data.accel_x)
                                            : MAG_W'(in_data.accel_x);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= SUM_W'(px);
      sq_y <= SUM_W'(py);
      sq_z <= SUM_W'(pz);
      tag1 <= tag1_next;
      tag_out    <= tag1;
      sum_out[0] <= sq_x + sq_z;
      sum_out[1] <= sq_y + sq_z;
    end
    if (rst) begin
      tag1.vld    <= 1'b0;
      tag_out.vld <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/atrp_isqrt.sv =====
// Pipelined digit-by-digit square root, one result bit per stage, two lanes.
module atrp_isqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  atrp_pkg::tag_t                       tag_in,
  input  logic [1:0][atrp_pkg::SUM_W-1:0]      sum_in,
  output atrp_pkg::tag_t                       tag_out,
  output logic [1:0][atrp_pkg::ROOT_W-1:0]     root_out
);
  import atrp_pkg::*;

  tag_t                        tag_q  [SQRT_STAGES+1];
  logic [1:0][SQRT_IN_W-1:0]   nsh_q  [SQRT_STAGES+1];
  logic [1:0][REM_W-1:0]       rem_q  [SQRT_STAGES+1];
  logic [1:0][ROOT_W-1:0]      root_q [SQRT_STAGES+1];

  assign tag_q[0]  = tag_in;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign nsh_q[0][0] = {sum_in[0], 16'd0};
  assign nsh_q[0][1] = {sum_in[1], 16'd0};

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [1:0][REM_W-1:0]  rem_next;
    logic [1:0][ROOT_W-1:0] root_next;

    always_comb begin
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;
      for (int l = 0; l < 2; l++) begin
        r2    = {rem_q[k][l], nsh_q[k][l][SQRT_IN_W-1 -: 2]};
        trial = {1'b0, root_q[k][l], 2'b01};
        if (r2 >= trial) begin
          rem_next[l]  = REM_W'(r2 - trial);
          root_next[l] = {root_q[k][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_next[l]  = REM_W'(r2);
          root_next[l] = {root_q[k][l][ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[k+1]  <= tag_q[k];
        rem_q[k+1]  <= rem_next;
        root_q[k+1] <= root_next;
        nsh_q[k+1][0] <= {nsh_q[k][0][SQRT_IN_W-3:0], 2'b00};
        nsh_q[k+1][1] <= {nsh_q[k][1][SQRT_IN_W-3:0], 2'b00};
      end
      if (rst) begin
        tag_q[k+1].vld <= 1'b0;
      end
    end
  end

  assign tag_out  = tag_q[SQRT_STAGES];
  assign root_out = root_q[SQRT_STAGES];

endmodule

// ===== hw/rtl/atrp_cordic.sv =====
// Pipelined CORDIC vectoring, one micro-rotation per stage, two lanes.
module atrp_cordic (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  atrp_pkg::tag_t                          tag_in,
  input  logic [1:0][atrp_pkg::ROOT_W-1:0]        root_in,
  output atrp_pkg::tag_t                          tag_out,
  output logic signed [atrp_pkg::Z_W-1:0]         z_out [2]
);
  import atrp_pkg::*;

  tag_t                    tag_q [CORDIC_ITER+1];
  logic signed [XY_W-1:0]  x_q   [CORDIC_ITER+1][2];
  logic signed [XY_W-1:0]  y_q   [CORDIC_ITER+1][2];
  logic signed [Z_W-1:0]   z_q   [CORDIC_ITER+1][2];

  assign tag_q[0] = tag_in;
  for (genvar l = 0; l < 2; l++) begin : g_init
    assign x_q[0][l] = XY_W'(root_in[l]);
    assign y_q[0][l] = XY_W'({tag_in.mag[l], 8'd0});
    assign z_q[0][l] = '0;
  end

  for (genvar i = 0; i < CORDIC_ITER; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] STEP = q30_round(ATAN_Q30[i]);
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [XY_W-1:0] dx, dy;
      assign dx = y_q[i][l] >>> i;
      assign dy = x_q[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (y_q[i][l] > 0) begin
            x_q[i+1][l] <= x_q[i][l] + dx;
            y_q[i+1][l] <= y_q[i][l] - dy;
            z_q[i+1][l] <= z_q[i][l] + STEP;
          end else begin
            x_q[i+1][l] <= x_q[i][l] - dx;
            y_q[i+1][l] <= y_q[i][l] + dy;
            z_q[i+1][l] <= z_q[i][l] - STEP;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_q[i+1] <= tag_q[i];
      end
      if (rst) begin
        tag_q[i+1].vld <= 1'b0;
      end
    end
  end

  assign tag_out  = tag_q[CORDIC_ITER];
  assign z_out[0] = z_q[CORDIC_ITER][0];
  assign z_out[1] = z_q[CORDIC_ITER][1];

endmodule

// ===== hw/rtl/accel_tilt_roll_pitch.sv =====
// Top level: roll and pitch tilt angles from one raw accelerometer sample.
//
// Input channel in_valid/in_stall/in_data carries one sample (x, y, z counts).
// Output channel out_valid/out_stall/out_data carries roll and pitch in
// radians (13 fraction bits) and the packed codes floor((angle + 10) * 10).
// A transaction is taken at a clock edge with valid high and stall low.
//
// The pipeline runs squares and sums, then the square root (one result bit
// per stage), then the CORDIC (one micro-rotation per stage), then clamping
// and code packing. One sample enters per cycle while in_stall is low.
//
// All stages advance together. While the output holds a result and
// out_stall is high, the whole pipeline freezes and in_stall is raised;
// nothing is dropped or repeated. Reset clears all valid bits; payload
// registers are not reset.
module accel_tilt_roll_pitch (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  atrp_pkg::accel_in_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output atrp_pkg::tilt_out_t   out_data
);
  import atrp_pkg::*;

  logic                     en;
  tag_t                     tag_s, tag_r, tag_c;
  logic [1:0][SUM_W-1:0]    sum_s;
  logic [1:0][ROOT_W-1:0]   root_r;
  logic signed [Z_W-1:0]    z_c [2];
  logic                     vld_f;
  logic signed [ANGLE_W-1:0] ang_f [2];
  logic signed [ANGLE_W-1:0] ang_next [2];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  atrp_sumsq u_sumsq (
    .clk, .rst, .en,
    .in_vld  (in_valid),
    .in_data (in_data),
    .tag_out (tag_s),
    .sum_out (sum_s)
  );

  atrp_isqrt u_isqrt (
    .clk, .rst, .en,
    .tag_in   (tag_s),
    .sum_in   (sum_s),
    .tag_out  (tag_r),
    .root_out (root_r)
  );

  atrp_cordic u_cordic (
    .clk, .rst, .en,
    .tag_in  (tag_r),
    .root_in (root_r),
    .tag_out (tag_c),
    .z_out   (z_c)
  );

  // clamp to [0, pi/2], then apply the numerator sign; a zero numerator gives zero
  always_comb begin
    logic signed [Z_W-1:0] c;
    for (int l = 0; l < 2; l++) begin
      if (z_c[l] < 0) begin
        c = '0;
      end else if (z_c[l] > $signed(HALF_PI)) begin
        c = HALF_PI;
      end else begin
        c = z_c[l];
      end
      if (tag_c.zero[l]) begin
        ang_next[l] = '0;
      end else if (tag_c.neg[l]) begin
        ang_next[l] = ANGLE_W'(-c);
      end else begin
        ang_next[l] = ANGLE_W'(c);
      end
    end
  end

  function automatic logic [CODE_W-1:0] pack_code(input logic signed [ANGLE_W-1:0] a);
    logic signed [22:0] t;
    t = (23'(a) <<< 3) + (23'(a) <<< 1) + 23'(100 << FRAC_BITS);
    return CODE_W'(t >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      vld_f    <= tag_c.vld;
      ang_f[0] <= ang_next[0];
      ang_f[1] <= ang_next[1];
      out_valid <= vld_f;
      out_data.roll_angle  <= ang_f[0];
      out_data.pitch_angle <= ang_f[1];
      out_data.roll_code   <= pack_code(ang_f[0]);
      out_data.pitch_code  <= pack_code(ang_f[1]);
    end
    if (rst) begin
      vld_f     <= 1'b0;
      out_valid <= 1'b0;
    end
  end

  a_code_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.roll_code >= CODE_W'(84) && out_data.roll_code <= CODE_W'(115)
                && out_data.pitch_code >= CODE_W'(84) && out_data.pitch_code <= CODE_W'(115)))
    else $error("tilt code out of range");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.roll_angle <= $signed(ANGLE_W'(HALF_PI))
                && out_data.roll_angle >= -$signed(ANGLE_W'(HALF_PI))
                && out_data.pitch_angle <= $signed(ANGLE_W'(HALF_PI))
                && out_data.pitch_angle >= -$signed(ANGLE_W'(HALF_PI))))
    else $error("tilt angle beyond pi/2");

  a_freeze : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld_f) && out_valid)
    else $error("pipeline moved while output stalled");

endmodule
